// ===== sv/position_p_controller_settle_macros.svh =====
// Assertion macros for the position controller block.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef POSITION_P_CONTROLLER_SETTLE_MACROS_SVH
`define POSITION_P_CONTROLLER_SETTLE_MACROS_SVH

// same-cycle implication
`define PPCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ppcs_pkg.sv =====
// Shared types, codes and constants for the position controller block.
// No dependencies; used by the step logic, the top level and the testbench.
package ppcs_pkg;

  localparam int unsigned SETTLE_TICKS = 50;
  localparam int unsigned CNT_W        = $clog2(SETTLE_TICKS + 2);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic signed [20:0] PI_Q     = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q = 21'sd411775;

  localparam logic [20:0] GAIN_POS_RST = 21'd19661;
  localparam logic [20:0] GAIN_YAW_RST = 21'd13107;
  localparam logic [30:0] LIM_XY_RST   = 31'd196608;
  localparam logic [30:0] LIM_Z_RST    = 31'd65536;
  localparam logic [30:0] POS_BAND_RST = 31'd16384;
  localparam logic [17:0] YAW_BAND_RST = 18'd6554;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_ABS = 2'd1,
    OP_SET_REL = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_POS = 3'd0,
    REG_GAIN_YAW = 3'd1,
    REG_LIM_XY   = 3'd2,
    REG_LIM_Z    = 3'd3,
    REG_POS_BAND = 3'd4,
    REG_YAW_BAND = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [20:0] gain_position;
    logic [20:0] gain_yaw;
    logic [30:0] limit_vel_xy;
    logic [30:0] limit_vel_z;
    logic [30:0] settle_pos_band;
    logic [17:0] settle_yaw_band;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0][31:0] cur;
    logic [18:0]      cur_yaw;
    logic [2:0][31:0] goal;
    logic [18:0]      goal_yaw;
    logic             hold_yaw;
  } item_t;

  typedef struct packed {
    logic             tracking;
    logic [2:0][31:0] target_pos;
    logic [18:0]      target_heading;
    logic [CNT_W-1:0] settle_count;
  } state_t;

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [31:0]      yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic fire;
  } step_ctl_t;

endpackage

// ===== sv/ppcs_if.sv =====
// Valid/ready channel interfaces for controller input items and result items.
// Depends on nothing; field names follow the item layout of the block.
interface ppcs_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] cur_z;
  logic signed [18:0] cur_yaw;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] goal_z;
  logic signed [18:0] goal_yaw;
  logic               hold_yaw;

  modport source (
    output valid, opcode, cur_x, cur_y, cur_z, cur_yaw,
           goal_x, goal_y, goal_z, goal_yaw, hold_yaw,
    input  ready
  );
  modport sink (
    input  valid, opcode, cur_x, cur_y, cur_z, cur_yaw,
           goal_x, goal_y, goal_z, goal_yaw, hold_yaw,
    output ready
  );
endinterface

interface ppcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] yaw_rate;
  logic               task_done;
  logic               last;

  modport source (
    output valid, vel_x, vel_y, vel_z, yaw_rate, task_done, last,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, yaw_rate, task_done, last,
    output ready
  );
endinterface

// ===== sv/ppcs_step.sv =====
// Single-pass controller step: target update, P terms, clamps, yaw wrap, settle count.
// Pure combinational; depends on ppcs_pkg.
module ppcs_step
  import ppcs_pkg::*;
(
  input  item_t     item_i,
  input  state_t    state_i,
  input  cfg_t      cfg_i,
  output state_t    state_o,
  output cmd_t      cmd_o,
  output step_ctl_t ctl_o
);

  function automatic logic [31:0] clamp_sym(logic signed [38:0] v, logic [30:0] lim);
    logic signed [38:0] l;
    logic [31:0]        r;
    l = $signed({8'd0, lim});
    if (v > l) r = {1'b0, lim};
    else if (v < -l) r = 32'(-l);
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] s;
    logic [31:0]        r;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = s[31:0];
    return r;
  endfunction

  logic signed [32:0] err     [3];
  logic        [32:0] err_mag [3];
  logic signed [54:0] prod    [3];
  logic        [31:0] vel     [3];
  logic signed [21:0] gain_pos_s;
  logic signed [21:0] gain_yaw_s;
  logic signed [20:0] yerr_raw;
  logic signed [20:0] yerr;
  logic        [20:0] yerr_mag;
  logic signed [42:0] yprod;
  logic               settled;
  logic [CNT_W-1:0]   cnt_inc;
  logic               tick_act;
  logic               fire;

  assign gain_pos_s = $signed({1'b0, cfg_i.gain_position});
  assign gain_yaw_s = $signed({1'b0, cfg_i.gain_yaw});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      err[i]     = $signed({state_i.target_pos[i][31], state_i.target_pos[i]})
                 - $signed({item_i.cur[i][31], item_i.cur[i]});
      err_mag[i] = err[i][32] ? 33'(-err[i]) : 33'(err[i]);
      prod[i]    = err[i] * gain_pos_s;
    end
    vel[0] = clamp_sym(prod[0][54:16], cfg_i.limit_vel_xy);
    vel[1] = clamp_sym(prod[1][54:16], cfg_i.limit_vel_xy);
    vel[2] = clamp_sym(prod[2][54:16], cfg_i.limit_vel_z);
  end

  always_comb begin
    yerr_raw = $signed({{2{state_i.target_heading[18]}}, state_i.target_heading})
             - $signed({{2{item_i.cur_yaw[18]}}, item_i.cur_yaw});
    if (yerr_raw > PI_Q) yerr = yerr_raw - TWO_PI_Q;
    else if (yerr_raw < -PI_Q) yerr = yerr_raw + TWO_PI_Q;
    else yerr = yerr_raw;
    yerr_mag = yerr[20] ? 21'(-yerr) : 21'(yerr);
    yprod    = yerr * gain_yaw_s;
  end

  assign settled = (err_mag[0] <= {2'd0, cfg_i.settle_pos_band})
                && (err_mag[1] <= {2'd0, cfg_i.settle_pos_band})
                && (err_mag[2] <= {2'd0, cfg_i.settle_pos_band})
                && (yerr_mag <= {3'd0, cfg_i.settle_yaw_band});

  assign cnt_inc  = state_i.settle_count + CNT_W'(settled);
  assign tick_act = (opcode_e'(item_i.opcode) == OP_TICK) && state_i.tracking;
  assign fire     = tick_act && (cnt_inc > CNT_W'(SETTLE_TICKS));

  always_comb begin
    state_o = state_i;
    unique case (opcode_e'(item_i.opcode))
      OP_SET_ABS, OP_SET_REL: begin
        for (int i = 0; i < 3; i++) begin
          state_o.target_pos[i] = (opcode_e'(item_i.opcode) == OP_SET_ABS) ? item_i.goal[i]
                                : sat_add(item_i.cur[i], item_i.goal[i]);
        end
        state_o.target_heading = item_i.hold_yaw ? item_i.cur_yaw : item_i.goal_yaw;
        state_o.tracking       = 1'b1;
      end
      OP_TICK: begin
        if (state_i.tracking) begin
          state_o.settle_count = fire ? '0 : cnt_inc;
          state_o.tracking     = !fire;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) cmd_o.vel[i] = vel[i];
    cmd_o.yaw_rate = {{5{yprod[42]}}, yprod[42:16]};
    ctl_o.emit     = tick_act;
    ctl_o.fire     = fire;
  end

endmodule

// ===== sv/position_p_controller_settle.sv =====
// Path: an accepted item is held in the input register, and a tick's result then in the result register.
// Throughput: one item per cycle while results are taken; a tick that ends tracking holds the result register
// for its command and then a zero done command. Set and idle items pass without touching the result register.
// Reset: registers to defaults, tracking off, targets and settle count zero, channels empty.
// Depends on ppcs_pkg, ppcs_if, ppcs_step and the assertion macro header.
`include "position_p_controller_settle_macros.svh"

module position_p_controller_settle
  import ppcs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppcs_in_if.sink               item_i,
  ppcs_out_if.source            res_o
);

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  item_t     in_item_q;
  logic      in_valid_q;
  cmd_t      cmd_d, out_cmd_q;
  step_ctl_t ctl;
  logic      out_valid_q;
  logic      out_done_q;
  logic      pend_done_q;
  logic      out_free;
  logic      advance;
  logic      in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_position   <= GAIN_POS_RST;
      cfg_q.gain_yaw        <= GAIN_YAW_RST;
      cfg_q.limit_vel_xy    <= LIM_XY_RST;
      cfg_q.limit_vel_z     <= LIM_Z_RST;
      cfg_q.settle_pos_band <= POS_BAND_RST;
      cfg_q.settle_yaw_band <= YAW_BAND_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GAIN_POS: cfg_q.gain_position   <= cfg_data_i[20:0];
        REG_GAIN_YAW: cfg_q.gain_yaw        <= cfg_data_i[20:0];
        REG_LIM_XY:   cfg_q.limit_vel_xy    <= cfg_data_i;
        REG_LIM_Z:    cfg_q.limit_vel_z     <= cfg_data_i;
        REG_POS_BAND: cfg_q.settle_pos_band <= cfg_data_i;
        REG_YAW_BAND: cfg_q.settle_yaw_band <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_q || (res_o.ready && !pend_done_q);
  assign advance      = in_valid_q && (!ctl.emit || out_free);
  assign item_i.ready = !in_valid_q || advance;
  assign in_take      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.opcode   <= item_i.opcode;
      in_item_q.cur[0]   <= item_i.cur_x;
      in_item_q.cur[1]   <= item_i.cur_y;
      in_item_q.cur[2]   <= item_i.cur_z;
      in_item_q.cur_yaw  <= item_i.cur_yaw;
      in_item_q.goal[0]  <= item_i.goal_x;
      in_item_q.goal[1]  <= item_i.goal_y;
      in_item_q.goal[2]  <= item_i.goal_z;
      in_item_q.goal_yaw <= item_i.goal_yaw;
      in_item_q.hold_yaw <= item_i.hold_yaw;
    end
  end

  ppcs_step u_step (
    .item_i  (in_item_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .cmd_o   (cmd_d),
    .ctl_o   (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register; a settle tick leaves a zero done command pending behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
      pend_done_q <= 1'b0;
    end else if (advance && ctl.emit) begin
      out_valid_q <= 1'b1;
      out_done_q  <= 1'b0;
      pend_done_q <= ctl.fire;
    end else if (out_valid_q && res_o.ready) begin
      if (pend_done_q) begin
        out_done_q  <= 1'b1;
        pend_done_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ctl.emit) begin
      out_cmd_q <= cmd_d;
    end else if (out_valid_q && res_o.ready && pend_done_q) begin
      out_cmd_q <= '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.vel_x     = out_cmd_q.vel[0];
  assign res_o.vel_y     = out_cmd_q.vel[1];
  assign res_o.vel_z     = out_cmd_q.vel[2];
  assign res_o.yaw_rate  = out_cmd_q.yaw_rate;
  assign res_o.task_done = out_done_q;
  assign res_o.last      = !pend_done_q;

  `PPCS_ASSERT_IMP(a_pend_needs_valid, pend_done_q, out_valid_q, "done pending without result")
  `PPCS_ASSERT_IMP(a_done_is_zero, out_valid_q && out_done_q,
                   (out_cmd_q == '0) && !pend_done_q, "done result not a final zero command")
  `PPCS_ASSERT_IMP(a_count_bound, 1'b1, state_q.settle_count <= CNT_W'(SETTLE_TICKS),
                   "settle count past limit")
  `PPCS_ASSERT_NXT(a_done_follows, out_valid_q && res_o.ready && pend_done_q,
                   out_valid_q && out_done_q, "done command did not follow")

endmodule

// ===== verif/ppcs_command_checker.sv =====
`timescale 1ns / 1ps
// Command checker for position_p_controller_settle: mirrors the register file,
// predicts the velocity commands that accepted items produce and compares results in order.
// Depends on ppcs_pkg and the ppcs_in_if / ppcs_out_if channel interfaces.
module ppcs_command_checker
  import ppcs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ppcs_in_if                    item_mon,
  ppcs_out_if                   res_mon,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam longint S32_HI = 2147483647;
  localparam longint S32_LO = -S32_HI - 1;

  typedef struct packed {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] yaw_rate;
    logic        task_done;
    logic        last;
  } velocity_cmd_t;

  cfg_t               regs;
  logic               track_on;
  logic signed [31:0] aim_pos [3];
  logic signed [18:0] aim_heading;
  int unsigned        settled_ticks;
  velocity_cmd_t      cmd_due [$];
  int                 fails = 0;

  function automatic void predict_commands(input item_t it);
    longint        sum, err, mag_err, lim, yaw_err, turn_rate;
    longint        vel [3];
    logic          in_band;
    velocity_cmd_t cmd;
    case (it.opcode)
      OP_SET_ABS, OP_SET_REL: begin
        for (int i = 0; i < 3; i++) begin
          if (it.opcode == OP_SET_ABS) begin
            aim_pos[i] = it.goal[i];
          end else begin
            sum = longint'($signed(it.cur[i])) + longint'($signed(it.goal[i]));
            if (sum > S32_HI) sum = S32_HI;
            else if (sum < S32_LO) sum = S32_LO;
            aim_pos[i] = sum[31:0];
          end
        end
        aim_heading = it.hold_yaw ? it.cur_yaw : it.goal_yaw;
        track_on = 1'b1;
      end
      OP_TICK: if (track_on) begin
        in_band = 1'b1;
        for (int i = 0; i < 3; i++) begin
          err = longint'(aim_pos[i]) - longint'($signed(it.cur[i]));
          vel[i] = (err * longint'(regs.gain_position)) >>> 16;
          lim = (i == 2) ? longint'(regs.limit_vel_z) : longint'(regs.limit_vel_xy);
          if (vel[i] > lim) vel[i] = lim;
          else if (vel[i] < -lim) vel[i] = -lim;
          mag_err = (err < 0) ? -err : err;
          if (mag_err > longint'(regs.settle_pos_band)) in_band = 1'b0;
        end
        yaw_err = longint'(aim_heading) - longint'($signed(it.cur_yaw));
        while (yaw_err > longint'(PI_Q)) yaw_err -= longint'(TWO_PI_Q);
        while (yaw_err < -longint'(PI_Q)) yaw_err += longint'(TWO_PI_Q);
        turn_rate = (yaw_err * longint'(regs.gain_yaw)) >>> 16;
        mag_err = (yaw_err < 0) ? -yaw_err : yaw_err;
        if (mag_err > longint'(regs.settle_yaw_band)) in_band = 1'b0;
        if (in_band) settled_ticks++;
        cmd.vel_x     = vel[0][31:0];
        cmd.vel_y     = vel[1][31:0];
        cmd.vel_z     = vel[2][31:0];
        cmd.yaw_rate  = turn_rate[31:0];
        cmd.task_done = 1'b0;
        cmd.last      = 1'b1;
        if (settled_ticks > SETTLE_TICKS) begin
          settled_ticks = 0;
          track_on      = 1'b0;
          cmd.last      = 1'b0;
          cmd_due       = {cmd_due, cmd};
          cmd           = '0;
          cmd.task_done = 1'b1;
          cmd.last      = 1'b1;
        end
        cmd_due = {cmd_due, cmd};
      end
      default: ;
    endcase
  endfunction

  task automatic note_failure(input string what, input velocity_cmd_t want,
                              input velocity_cmd_t got);
    fails++;
    if (fails <= 10)
      $display("[%0t] %s: expected x=%0d y=%0d z=%0d yaw=%0d done=%0b last=%0b,\n",
               $time, what, $signed(want.vel_x), $signed(want.vel_y), $signed(want.vel_z),
               $signed(want.yaw_rate), want.task_done, want.last,
               "    got x=%0d y=%0d z=%0d yaw=%0d done=%0b last=%0b",
               $signed(got.vel_x), $signed(got.vel_y), $signed(got.vel_z),
               $signed(got.yaw_rate), got.task_done, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    velocity_cmd_t got, want;
    item_t         seen;
    if (!rst_ni) begin
      regs = '{gain_position: GAIN_POS_RST, gain_yaw: GAIN_YAW_RST,
               limit_vel_xy: LIM_XY_RST, limit_vel_z: LIM_Z_RST,
               settle_pos_band: POS_BAND_RST, settle_yaw_band: YAW_BAND_RST};
      track_on      = 1'b0;
      aim_pos[0]    = '0;
      aim_pos[1]    = '0;
      aim_pos[2]    = '0;
      aim_heading   = '0;
      settled_ticks = 0;
      cmd_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GAIN_POS: regs.gain_position   = cfg_data_i[20:0];
          REG_GAIN_YAW: regs.gain_yaw        = cfg_data_i[20:0];
          REG_LIM_XY:   regs.limit_vel_xy    = cfg_data_i[30:0];
          REG_LIM_Z:    regs.limit_vel_z     = cfg_data_i[30:0];
          REG_POS_BAND: regs.settle_pos_band = cfg_data_i[30:0];
          REG_YAW_BAND: regs.settle_yaw_band = cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        got.vel_x     = res_mon.vel_x;
        got.vel_y     = res_mon.vel_y;
        got.vel_z     = res_mon.vel_z;
        got.yaw_rate  = res_mon.yaw_rate;
        got.task_done = res_mon.task_done;
        got.last      = res_mon.last;
        if (cmd_due.size() == 0) begin
          note_failure("result with none due", '0, got);
        end else begin
          want = cmd_due.pop_front();
          if (got !== want) note_failure("command mismatch", want, got);
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        seen.opcode   = item_mon.opcode;
        seen.cur[0]   = item_mon.cur_x;
        seen.cur[1]   = item_mon.cur_y;
        seen.cur[2]   = item_mon.cur_z;
        seen.cur_yaw  = item_mon.cur_yaw;
        seen.goal[0]  = item_mon.goal_x;
        seen.goal[1]  = item_mon.goal_y;
        seen.goal[2]  = item_mon.goal_z;
        seen.goal_yaw = item_mon.goal_yaw;
        seen.hold_yaw = item_mon.hold_yaw;
        predict_commands(seen);
      end
    end
    fail_count_o <= fails;
    pending_o    <= cmd_due.size();
  end

endmodule

// ===== verif/tb_position_p_controller_settle.sv =====
`timescale 1ns / 1ps
// Testbench top for position_p_controller_settle: clock, reset, register phases,
// target/tick stimulus and result back-pressure; ppcs_command_checker does the checking.
// Depends on ppcs_pkg, ppcs_if, the block and ppcs_command_checker.
module tb_position_p_controller_settle;
  import ppcs_pkg::*;

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          LONG_HOLD   = 200;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam longint      S32_HI      = 2147483647;
  localparam longint      S32_LO      = -S32_HI - 1;
  localparam logic [31:0] W_MAX       = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN       = 32'h8000_0000;
  localparam logic [18:0] YAW_TOP     = 19'd205887;
  localparam logic [18:0] YAW_BOTTOM  = -19'sd205887;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  bit                    calm;
  bit                    hold_req;
  cfg_t                  live_cfg;
  longint                aim [3];
  longint                aim_yaw;
  int                    cycles;

  ppcs_in_if  item_ch ();
  ppcs_out_if res_ch ();

  position_p_controller_settle DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_ch),
    .res_o       (res_ch)
  );

  ppcs_command_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_mon     (item_ch),
    .res_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat_word(input longint v);
    if (v > S32_HI) v = S32_HI;
    else if (v < S32_LO) v = S32_LO;
    return v[31:0];
  endfunction

  function automatic logic [31:0] near_axis(input longint center, input longint band);
    longint span, v;
    span = ($urandom_range(0, 7) == 0) ? band * 4 + 64 : band;
    if (span > S32_HI) span = S32_HI;
    v = longint'($urandom_range(0, 32'(span)));
    return sat_word($urandom_range(0, 1) ? center + v : center - v);
  endfunction

  function automatic logic [18:0] near_yaw(input longint center, input longint band);
    longint span, v;
    span = ($urandom_range(0, 7) == 0) ? band * 4 + 64 : band;
    if (span > longint'(TWO_PI_Q)) span = longint'(TWO_PI_Q);
    v = longint'($urandom_range(0, 32'(span)));
    v = $urandom_range(0, 1) ? center + v : center - v;
    if (v > longint'(PI_Q)) v -= longint'(TWO_PI_Q);
    else if (v < -longint'(PI_Q)) v += longint'(TWO_PI_Q);
    if (v > longint'(PI_Q)) v = longint'(PI_Q);
    else if (v < -longint'(PI_Q)) v = -longint'(PI_Q);
    return 19'(v);
  endfunction

  function automatic logic [18:0] wild_yaw();
    return 19'(longint'($urandom_range(0, 411774)) - longint'(PI_Q));
  endfunction

  function automatic item_t pose(input logic [1:0] op, input logic [31:0] x, y, z,
                                 input logic [18:0] yaw, input logic [31:0] gx, gy, gz,
                                 input logic [18:0] gyaw, input logic hold);
    item_t it;
    it.opcode   = op;
    it.cur[0]   = x;
    it.cur[1]   = y;
    it.cur[2]   = z;
    it.cur_yaw  = yaw;
    it.goal[0]  = gx;
    it.goal[1]  = gy;
    it.goal[2]  = gz;
    it.goal_yaw = gyaw;
    it.hold_yaw = hold;
    return it;
  endfunction

  function automatic item_t wild_item();
    return pose(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), wild_yaw(),
                $urandom(), $urandom(), $urandom(), wild_yaw(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic item_t fresh_target();
    item_t it;
    int    offset;
    it = wild_item();
    it.opcode = ($urandom_range(0, 2) == 0) ? OP_SET_REL : OP_SET_ABS;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 1)) it.cur[i] = near_axis(aim[i], longint'(1 << 20));
      offset = $urandom_range(0, 2097152);
      if ($urandom_range(0, 1)) it.goal[i] = offset - 1048576;
    end
    it.hold_yaw = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic item_t tick_near();
    item_t it;
    it = wild_item();
    it.opcode = OP_TICK;
    for (int i = 0; i < 3; i++)
      it.cur[i] = near_axis(aim[i], longint'(live_cfg.settle_pos_band));
    it.cur_yaw = near_yaw(aim_yaw, longint'(live_cfg.settle_yaw_band));
    return it;
  endfunction

  task automatic offer(input item_t it);
    if (it.opcode == OP_SET_ABS || it.opcode == OP_SET_REL) begin
      for (int i = 0; i < 3; i++)
        aim[i] = (it.opcode == OP_SET_ABS) ? longint'($signed(it.goal[i])) :
                 longint'($signed(sat_word(longint'($signed(it.cur[i])) +
                                           longint'($signed(it.goal[i])))));
      aim_yaw = it.hold_yaw ? longint'($signed(it.cur_yaw)) : longint'($signed(it.goal_yaw));
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    item_ch.valid    <= 1'b1;
    item_ch.opcode   <= it.opcode;
    item_ch.cur_x    <= it.cur[0];
    item_ch.cur_y    <= it.cur[1];
    item_ch.cur_z    <= it.cur[2];
    item_ch.cur_yaw  <= it.cur_yaw;
    item_ch.goal_x   <= it.goal[0];
    item_ch.goal_y   <= it.goal[1];
    item_ch.goal_z   <= it.goal[2];
    item_ch.goal_yaw <= it.goal_yaw;
    item_ch.hold_yaw <= it.hold_yaw;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GAIN_POS;
    cfg_data_i  <= {10'd0, s.gain_position};
    @(posedge clk_i);
    cfg_index_i <= REG_GAIN_YAW;
    cfg_data_i  <= {10'd0, s.gain_yaw};
    @(posedge clk_i);
    cfg_index_i <= REG_LIM_XY;
    cfg_data_i  <= s.limit_vel_xy;
    @(posedge clk_i);
    cfg_index_i <= REG_LIM_Z;
    cfg_data_i  <= s.limit_vel_z;
    @(posedge clk_i);
    cfg_index_i <= REG_POS_BAND;
    cfg_data_i  <= s.settle_pos_band;
    @(posedge clk_i);
    cfg_index_i <= REG_YAW_BAND;
    cfg_data_i  <= {13'd0, s.settle_yaw_band};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    live_cfg = s;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.gain_position   = 21'($urandom_range(0, 1) ? $urandom_range(0, 1048576) :
                                                   $urandom_range(0, 131072));
    s.gain_yaw        = 21'($urandom_range(0, 1) ? $urandom_range(0, 1048576) :
                                                   $urandom_range(0, 131072));
    s.limit_vel_xy    = 31'($urandom() >> $urandom_range(1, 31));
    s.limit_vel_z     = 31'($urandom() >> $urandom_range(1, 31));
    s.settle_pos_band = 31'($urandom_range(0, 1 << $urandom_range(0, 20)));
    s.settle_yaw_band = 18'($urandom_range(0, 1 << $urandom_range(0, 17)));
    return s;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned sent, run;
    sent = 0;
    while (sent < count) begin
      offer(fresh_target());
      sent++;
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      repeat (run) begin
        if ($urandom_range(0, 15) == 0) offer(wild_item());
        else offer(tick_near());
        sent++;
      end
    end
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    cfg_t        phase_cfg;
    int unsigned phase;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= REG_GAIN_POS;
    cfg_data_i       <= '0;
    item_ch.valid    <= 1'b0;
    item_ch.opcode   <= OP_TICK;
    item_ch.cur_x    <= '0;
    item_ch.cur_y    <= '0;
    item_ch.cur_z    <= '0;
    item_ch.cur_yaw  <= '0;
    item_ch.goal_x   <= '0;
    item_ch.goal_y   <= '0;
    item_ch.goal_z   <= '0;
    item_ch.goal_yaw <= '0;
    item_ch.hold_yaw <= 1'b0;
    cycles   = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    live_cfg = '{gain_position: GAIN_POS_RST, gain_yaw: GAIN_YAW_RST,
                 limit_vel_xy: LIM_XY_RST, limit_vel_z: LIM_Z_RST,
                 settle_pos_band: POS_BAND_RST, settle_yaw_band: YAW_BAND_RST};
    aim[0]  = 0;
    aim[1]  = 0;
    aim[2]  = 0;
    aim_yaw = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(pose(OP_TICK, 32'd5, -32'd5, 32'd9, 19'd100, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_UNUSED, W_MAX, W_MIN, 32'd1, YAW_TOP, W_MIN, W_MAX, '1, YAW_BOTTOM, 1'b1));
    offer(pose(OP_SET_ABS, '0, '0, '0, '0, W_MAX, W_MAX, W_MAX, YAW_TOP, 1'b0));
    offer(pose(OP_TICK, W_MIN, W_MIN, W_MIN, YAW_BOTTOM, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_TICK, W_MAX, W_MAX, W_MAX, YAW_TOP, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_ABS, '0, '0, '0, '0, W_MIN, W_MIN, W_MIN, YAW_BOTTOM, 1'b0));
    offer(pose(OP_TICK, W_MAX, W_MAX, W_MAX, YAW_TOP, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_REL, W_MAX, W_MAX, W_MAX, '0, W_MAX, W_MAX, W_MAX, YAW_TOP, 1'b1));
    offer(pose(OP_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_REL, W_MIN, W_MIN, W_MIN, YAW_BOTTOM, W_MIN, W_MIN, W_MIN, '0, 1'b0));
    offer(pose(OP_TICK, '0, '0, '0, YAW_TOP, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_REL, 32'd1000, -32'd1000, '0, 19'd12345,
               -32'd3000, 32'd3000, 32'd7, YAW_BOTTOM, 1'b1));
    offer(pose(OP_TICK, -32'd2000, 32'd2000, 32'd7, 19'd12345, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_TICK, 32'd14384, -32'd14384, 32'd16391, 19'd5791, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_TICK, -32'd18385, 32'd18385, -32'd16378, 19'd18900, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_ABS, '0, '0, '0, YAW_BOTTOM, 32'd100, 32'd200, 32'd300, YAW_TOP, 1'b1));
    offer(pose(OP_TICK, 32'd101, 32'd200, 32'd300, YAW_TOP, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_TICK, 32'd99, 32'd201, 32'd299, YAW_BOTTOM, '0, '0, '0, '0, 1'b0));
    offer(pose(OP_SET_ABS, '0, '0, '0, '0, -32'd65536, 32'd65536, -32'd131072, '0, 1'b0));
    offer(pose(OP_TICK, 32'd10000000, -32'd10000000, 32'd10000000, 19'd3, '0, '0, '0, '0,
               1'b0));
    offer(pose(OP_TICK, -32'd10000000, 32'd10000000, -32'd10000000, -19'sd3, '0, '0, '0, '0,
               1'b0));
    drain_results();
    run_random(320);
    drain_results();

    for (phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: phase_cfg = '{gain_position: 21'd1048576, gain_yaw: 21'd1048576,
                         limit_vel_xy: '1, limit_vel_z: '1,
                         settle_pos_band: '1, settle_yaw_band: 18'd205887};
        2: phase_cfg = '0;
        default: phase_cfg = random_settings();
      endcase
      load_settings(phase_cfg);
      if (phase == 3) begin
        offer(fresh_target());
        hold_req = 1'b1;
        repeat (40) offer(tick_near());
        drain_results();
      end
      if (phase == 5) begin
        run_random(140);
        calm = 1'b1;
        run_random(140);
      end else begin
        run_random(280);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
